### design/tbs_pkg.sv
// shared constants and types for the triangle barycentric setup block
// no dependencies
`timescale 1ns / 1ps

package tbs_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 40;
  localparam int COEF_W          = 64;
  localparam int N_LANES         = 9;
  localparam int N_FIELDS_IN     = 6;
  localparam int PREP_STAGES     = 4;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t [N_LANES-1:0] coef;
    logic                degen;
  } result_t;

endpackage

### design/tbs_prep.sv
// front end: determinant, numerators, magnitudes and divider seed
// depends on tbs_pkg
`timescale 1ns / 1ps

module tbs_prep #(
  parameter int CW = 24,
  parameter int FB = 40
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [CW-1:0]  vx_i [3],
  input  logic signed [CW-1:0]  vy_i [3],
  output logic [2*CW+1:0]       rem_o [tbs_pkg::N_LANES],
  output logic [tbs_pkg::COEF_W-1:0] nq_o [tbs_pkg::N_LANES],
  output logic [tbs_pkg::N_LANES-1:0] ovf_o,
  output logic [tbs_pkg::N_LANES-1:0] neg_o,
  output logic [2*CW:0]         den_o,
  output logic                  degen_o
);
  import tbs_pkg::*;

  localparam int DW = 2 * CW + 1;
  localparam int NX = DW + 1 + COEF_W;
  localparam int NS = 2 * CW + 1;

  logic signed [CW-1:0]     x_r [3];
  logic signed [CW-1:0]     y_r [3];
  logic signed [2*CW+1:0]   pd1_r, pd2_r;
  logic signed [2*CW-1:0]   pj_r [3];
  logic signed [2*CW-1:0]   pl_r [3];
  logic signed [CW:0]       na_r [3];
  logic signed [CW:0]       nb_r [3];
  logic [2*CW-1:0]          mag_r [N_LANES];
  logic [N_LANES-1:0]       nneg_r;
  logic [DW-1:0]            den2_r;
  logic                     degen2_r;
  logic [DW:0]              rem_r [N_LANES];
  logic [COEF_W-1:0]        nq_r [N_LANES];
  logic [N_LANES-1:0]       ovf_r, neg_r;
  logic [DW-1:0]            den_r;
  logic                     degen_r;

  logic signed [CW:0]       dx1, dx2, dy1, dy2;
  logic signed [2*CW+2:0]   dsum, dabs;
  logic signed [NS-1:0]     nv [N_LANES];
  logic signed [NS-1:0]     nabs [N_LANES];
  logic [NX-1:0]            numx [N_LANES];

  always_comb begin
    dx1 = (CW+1)'(x_r[1]) - (CW+1)'(x_r[0]);
    dx2 = (CW+1)'(x_r[2]) - (CW+1)'(x_r[0]);
    dy1 = (CW+1)'(y_r[1]) - (CW+1)'(y_r[0]);
    dy2 = (CW+1)'(y_r[2]) - (CW+1)'(y_r[0]);
    dsum = (2*CW+3)'(pd1_r) - (2*CW+3)'(pd2_r);
    dabs = dsum[2*CW+2] ? -dsum : dsum;
    for (int k = 0; k < 3; k++) begin
      nv[3*k]   = NS'(na_r[k]);
      nv[3*k+1] = NS'(nb_r[k]);
      nv[3*k+2] = NS'(pj_r[k]) - NS'(pl_r[k]);
    end
    for (int i = 0; i < N_LANES; i++) begin
      nabs[i] = nv[i][NS-1] ? -nv[i] : nv[i];
      numx[i] = NX'(mag_r[i]) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= vx_i;
      y_r <= vy_i;
      pd1_r <= dx1 * dy2;
      pd2_r <= dx2 * dy1;
      for (int k = 0; k < 3; k++) begin
        pj_r[k] <= x_r[(k+1)%3] * y_r[(k+2)%3];
        pl_r[k] <= x_r[(k+2)%3] * y_r[(k+1)%3];
        na_r[k] <= (CW+1)'(y_r[(k+1)%3]) - (CW+1)'(y_r[(k+2)%3]);
        nb_r[k] <= (CW+1)'(x_r[(k+2)%3]) - (CW+1)'(x_r[(k+1)%3]);
      end
      den2_r   <= dabs[DW-1:0];
      degen2_r <= (dsum == '0);
      for (int i = 0; i < N_LANES; i++) begin
        mag_r[i]  <= nabs[i][2*CW-1:0];
        nneg_r[i] <= nv[i][NS-1] ^ dsum[2*CW+2];
      end
      den_r   <= den2_r;
      degen_r <= degen2_r;
      neg_r   <= nneg_r;
      for (int i = 0; i < N_LANES; i++) begin
        rem_r[i] <= numx[i][NX-1:COEF_W];
        nq_r[i]  <= numx[i][COEF_W-1:0];
        ovf_r[i] <= numx[i][NX-1:COEF_W] >= {1'b0, den2_r};
      end
    end
  end

  assign rem_o   = rem_r;
  assign nq_o    = nq_r;
  assign ovf_o   = ovf_r;
  assign neg_o   = neg_r;
  assign den_o   = den_r;
  assign degen_o = degen_r;

endmodule

### design/tbs_div_cell.sv
// one restoring division step for one coefficient lane
// depends on tbs_pkg
`timescale 1ns / 1ps

module tbs_div_cell #(
  parameter int DW = 49
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [DW:0]                rem_i,
  input  logic [tbs_pkg::COEF_W-1:0] nq_i,
  input  logic [DW-1:0]              den_i,
  input  logic                       ovf_i,
  input  logic                       neg_i,
  output logic [DW:0]                rem_o,
  output logic [tbs_pkg::COEF_W-1:0] nq_o,
  output logic [DW-1:0]              den_o,
  output logic                       ovf_o,
  output logic                       neg_o
);
  import tbs_pkg::*;

  logic [DW:0]         rem_r, rem_nxt, sh;
  logic [COEF_W-1:0]   nq_r, nq_nxt;
  logic [DW-1:0]       den_r;
  logic                ovf_r, neg_r;
  logic [DW+1:0]       diff;
  logic                ge;

  always_comb begin
    sh      = {rem_i[DW-1:0], nq_i[COEF_W-1]};
    diff    = {1'b0, sh} - {2'b00, den_i};
    ge      = ~diff[DW+1];
    rem_nxt = ge ? diff[DW:0] : sh;
    nq_nxt  = {nq_i[COEF_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den_i;
      ovf_r <= ovf_i;
      neg_r <= neg_i;
    end
  end

  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;
  assign ovf_o = ovf_r;
  assign neg_o = neg_r;

endmodule

### design/triangle_barycentric_setup.sv
// top level: front end, 64-cell division chain per lane, saturation, output queue
// depends on tbs_pkg, tbs_prep, tbs_div_cell
//
// channel  dir  tdata                               tuser
// in_      in   vx0,vy0,vx1,vy1,vx2,vy2 (CW each)   -
// out_     out  a0,b0,c0,a1,b1,c1,a2,b2,c2 (64 ea)  degenerate
//
// one triangle per cycle while the output queue is not full; 4 setup stages, 64 division cells,
// one saturation step into a two-beat output queue
// the whole pipeline advances unless the output queue is full
// reset clears valid bits and queue pointers only
`timescale 1ns / 1ps

module triangle_barycentric_setup #(
  parameter int COORD_WIDTH = tbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tbs_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vx0, vy0, vx1, vy1, vx2, vy2
  input  logic [((tbs_pkg::N_FIELDS_IN*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // coef_a0, coef_b0, coef_c0, coef_a1, coef_b1, coef_c1, coef_a2, coef_b2, coef_c2
  output logic [tbs_pkg::N_LANES*tbs_pkg::COEF_W-1:0] out_tdata,
  // degenerate
  output logic out_tuser
);
  import tbs_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * CW + 1;
  localparam int NSTEP = COEF_W;
  localparam int L = PREP_STAGES + NSTEP;

  logic                en;
  logic [L-1:0]        v_r;
  logic [NSTEP-1:0]    degen_r;
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];

  logic [DW:0]         rem_c [NSTEP+1][N_LANES];
  logic [COEF_W-1:0]   nq_c  [NSTEP+1][N_LANES];
  logic [DW-1:0]       den_c [NSTEP+1][N_LANES];
  logic [N_LANES-1:0]  ovf_c [NSTEP+1];
  logic [N_LANES-1:0]  neg_c [NSTEP+1];
  logic [DW-1:0]       den0;
  logic                degen0;

  result_t             mem_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  logic                push, pop;
  result_t             res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = in_tdata[2*k*CW +: CW];
      vy[k] = in_tdata[(2*k+1)*CW +: CW];
    end
  end

  tbs_prep #(.CW(CW), .FB(FRAC_BITS)) u_prep (
    .clk(clk), .en(en), .vx_i(vx), .vy_i(vy),
    .rem_o(rem_c[0]), .nq_o(nq_c[0]), .ovf_o(ovf_c[0]), .neg_o(neg_c[0]),
    .den_o(den0), .degen_o(degen0)
  );

  always_comb begin
    for (int i = 0; i < N_LANES; i++) den_c[0][i] = den0;
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    for (genvar i = 0; i < N_LANES; i++) begin : g_lane
      tbs_div_cell #(.DW(DW)) u_cell (
        .clk(clk), .en(en),
        .rem_i(rem_c[s][i]), .nq_i(nq_c[s][i]), .den_i(den_c[s][i]),
        .ovf_i(ovf_c[s][i]), .neg_i(neg_c[s][i]),
        .rem_o(rem_c[s+1][i]), .nq_o(nq_c[s+1][i]), .den_o(den_c[s+1][i]),
        .ovf_o(ovf_c[s+1][i]), .neg_o(neg_c[s+1][i])
      );
    end
  end

  // saturate, apply sign, zero on degenerate
  always_comb begin
    logic [COEF_W-1:0] lim, m;
    lim = '0;
    m   = '0;
    res.degen = degen_r[NSTEP-1];
    for (int i = 0; i < N_LANES; i++) begin
      lim = neg_c[NSTEP][i] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      m   = (ovf_c[NSTEP][i] || nq_c[NSTEP][i] > lim) ? lim : nq_c[NSTEP][i];
      res.coef[i] = degen_r[NSTEP-1] ? '0 : (neg_c[NSTEP][i] ? -m : m);
    end
  end

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && v_r[L-1];
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (en) v_r <= {v_r[L-2:0], in_tvalid};
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (en) degen_r <= {degen_r[NSTEP-2:0], degen0};
    if (push) mem_r[wp_r] <= res;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = mem_r[rp_r].coef;
  assign out_tuser  = mem_r[rp_r].degen;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output queue count out of range");
  a_no_ovfl: assert property (@(posedge clk) disable iff (!rst_n)
    !(v_r[L-1] && cnt_r == 2'd2 && !pop) |=> cnt_r != 2'd3)
    else $error("output queue overflow");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate beat with nonzero coefficients");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_tready)
    else $error("input accepted while queue full");

endmodule
